FILE: hw/rtl/nur_pkg.sv
// shared types and constants for the not-used-recently replacement policy
// used by nur_cell and nur_replacement_policy; no dependencies

package nur_pkg;

    // number of cache blocks tracked
    localparam int NUM_BLOCKS   = 16;
    localparam int IDX_W        = (NUM_BLOCKS > 1) ? $clog2(NUM_BLOCKS) : 1;
    localparam int CNT_W        = $clog2(NUM_BLOCKS + 1);

    // fixed field widths
    localparam int REQ_W        = 3;
    localparam int BLK_W        = 4;
    localparam int PERIOD_W     = 16;
    localparam logic [PERIOD_W-1:0] PERIOD_RESET = 16'd150;

    // rank encoding for the victim search: invalid blocks rank lowest,
    // valid blocks rank 1 + 2*referenced + modified
    localparam int RANK_W       = 3;
    localparam logic [RANK_W-1:0] RANK_INVALID = 3'd0;
    localparam logic [RANK_W-1:0] RANK_NONE    = 3'd5;

    // request codes
    typedef enum logic [REQ_W-1:0] {
        REQ_READ    = 3'd0,
        REQ_WRITE   = 3'd1,
        REQ_REPLACE = 3'd2,
        REQ_CLEAR   = 3'd3,
        REQ_STATUS  = 3'd4
    } req_t;

    // controller states
    typedef enum logic {
        ST_IDLE,
        ST_SCAN
    } state_t;

    // broadcast controls to every cell
    typedef struct packed {
        logic clear_refs;
        logic set_ref_en;
        logic set_status_en;
        logic new_valid;
        logic new_modified;
    } cell_ctl_t;

    // search token passed along the cell chain
    typedef struct packed {
        logic [RANK_W-1:0] rank;
        logic [IDX_W-1:0]  idx;
    } token_t;

endpackage

FILE: hw/rtl/nur_replacement_policy.sv
// Not-used-recently replacement policy, top level with request control.
// Access, clear and status results come in the cycle after acceptance; a replace
// result comes once the search token, passing one cell of the chain per cycle, has
// cleared the last cell and the output is free; a replace blocks new requests till then.
// Throughput: one non-replace transaction per cycle unless the result channel stalls.
// Reset: synchronous active-low aresetn clears the block bits; period and count go to 150.

module nur_replacement_policy (
    input  logic        aclk,
    input  logic        aresetn,
    // input channel
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // block_index[3:0], block_valid[4], block_modified[5], 0
    input  logic [2:0]  s_tuser,   // req_type[2:0]
    // result channel
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,   // victim_index[3:0], references_cleared[4], 0
    output logic        m_tuser,   // victim_given[0]
    // configuration port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import nur_pkg::*;

    state_t                 state_reg, state_next;
    logic [CNT_W-1:0]       cnt_reg, cnt_next;
    logic [PERIOD_W-1:0]    period_reg, period_next;
    logic [PERIOD_W-1:0]    countdown_reg, countdown_next;
    logic [PERIOD_W-1:0]    count_dec;
    logic                   m_tvalid_reg, m_tvalid_next;
    logic [BLK_W-1:0]       victim_reg, victim_next;
    logic                   given_reg, given_next;
    logic                   cleared_reg, cleared_next;

    logic                   accept;
    logic                   cfg_write;
    logic                   out_free;
    logic [BLK_W-1:0]       blk_idx;
    cell_ctl_t              ctl;
    token_t                 chain [NUM_BLOCKS+1];
    logic [NUM_BLOCKS-1:0]  sel;

    assign blk_idx   = s_tdata[3:0];
    assign out_free  = !m_tvalid_reg || m_tready;
    assign s_tready  = (state_reg == ST_IDLE) && out_free;
    assign accept    = s_tvalid && s_tready;
    assign cfg_write = psel && penable && pwrite && pready && !paddr[2];

    // apb read side
    assign pready = 1'b1;
    assign prdata = paddr[2] ? 32'd0 : {16'd0, period_reg};

    // search seed enters the chain head
    assign chain[0].rank = RANK_NONE;
    assign chain[0].idx  = '0;

    // row of status cells
    for (genvar i = 0; i < NUM_BLOCKS; i++) begin : g_cell
        assign sel[i] = (int'(blk_idx) == i);
        nur_cell u_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .ctl       (ctl),
            .sel       (sel[i]),
            .cell_id   (IDX_W'(i)),
            .token_in  (chain[i]),
            .token_out (chain[i+1])
        );
    end

    assign count_dec = PERIOD_W'(countdown_reg - 16'd1);

    // request decode, countdown and result control
    always_comb begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        period_next    = period_reg;
        countdown_next = countdown_reg;
        m_tvalid_next  = m_tvalid_reg && !m_tready;
        victim_next    = victim_reg;
        given_next     = given_reg;
        cleared_next   = cleared_reg;
        ctl            = '0;
        ctl.new_valid    = s_tdata[4];
        ctl.new_modified = s_tdata[5];

        if (cfg_write) begin
            period_next    = pwdata[PERIOD_W-1:0];
            countdown_next = pwdata[PERIOD_W-1:0];
        end

        case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    victim_next  = '0;
                    given_next   = 1'b0;
                    cleared_next = 1'b0;
                    m_tvalid_next = 1'b1;
                    case (s_tuser)
                        REQ_READ, REQ_WRITE: begin
                            ctl.set_ref_en = 1'b1;
                            if (period_reg != '0) begin
                                if (count_dec == '0) begin
                                    ctl.clear_refs = 1'b1;
                                    countdown_next = period_reg;
                                    cleared_next   = 1'b1;
                                end else begin
                                    countdown_next = count_dec;
                                end
                            end
                        end
                        REQ_REPLACE: begin
                            m_tvalid_next = 1'b0;
                            state_next    = ST_SCAN;
                            cnt_next      = '0;
                        end
                        REQ_CLEAR: begin
                            if (period_reg != '0) begin
                                ctl.clear_refs = 1'b1;
                                countdown_next = period_reg;
                                cleared_next   = 1'b1;
                            end
                        end
                        REQ_STATUS: begin
                            ctl.set_status_en = 1'b1;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            ST_SCAN: begin
                // wait for the token to clear the last cell, then hand it out
                if (cnt_reg != CNT_W'(NUM_BLOCKS)) begin
                    cnt_next = CNT_W'(cnt_reg + 1'b1);
                end else if (out_free) begin
                    victim_next   = BLK_W'(chain[NUM_BLOCKS].idx);
                    given_next    = 1'b1;
                    cleared_next  = 1'b0;
                    m_tvalid_next = 1'b1;
                    state_next    = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            cnt_reg       <= '0;
            period_reg    <= PERIOD_RESET;
            countdown_reg <= PERIOD_RESET;
            m_tvalid_reg  <= 1'b0;
        end else begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            period_reg    <= period_next;
            countdown_reg <= countdown_next;
            m_tvalid_reg  <= m_tvalid_next;
        end
    end

    // result payload
    always_ff @(posedge aclk) begin
        victim_reg  <= victim_next;
        given_reg   <= given_next;
        cleared_reg <= cleared_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {3'd0, cleared_reg, victim_reg};
    assign m_tuser  = given_reg;

endmodule

FILE: hw/rtl/nur_cell.sv
// one block's status cell: valid, modified and referenced bits plus one
// stage of the registered victim search chain; depends on nur_pkg

module nur_cell (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  nur_pkg::cell_ctl_t      ctl,
    input  logic                    sel,
    input  logic [nur_pkg::IDX_W-1:0] cell_id,
    input  nur_pkg::token_t         token_in,
    output nur_pkg::token_t         token_out
);
    import nur_pkg::*;

    logic       valid_reg, valid_next;
    logic       modified_reg, modified_next;
    logic       referenced_reg, referenced_next;
    token_t     token_reg, token_next;
    logic [RANK_W-1:0] my_rank;

    // per-block bit updates; a set after a clear in the same transaction wins
    always_comb begin
        valid_next      = valid_reg;
        modified_next   = modified_reg;
        referenced_next = referenced_reg;
        if (ctl.clear_refs) begin
            referenced_next = 1'b0;
        end
        if (ctl.set_ref_en && sel) begin
            referenced_next = 1'b1;
        end
        if (ctl.set_status_en && sel) begin
            valid_next    = ctl.new_valid;
            modified_next = ctl.new_modified;
        end
    end

    // rank of this block and compare against the incoming token
    always_comb begin
        if (valid_reg) begin
            my_rank = RANK_W'(3'd1 + {1'b0, referenced_reg, modified_reg});
        end else begin
            my_rank = RANK_INVALID;
        end
        if (my_rank < token_in.rank) begin
            token_next.rank = my_rank;
            token_next.idx  = cell_id;
        end else begin
            token_next = token_in;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg      <= 1'b0;
            modified_reg   <= 1'b0;
            referenced_reg <= 1'b0;
        end else begin
            valid_reg      <= valid_next;
            modified_reg   <= modified_next;
            referenced_reg <= referenced_next;
        end
    end

    // search stage register
    always_ff @(posedge aclk) begin
        token_reg <= token_next;
    end

    assign token_out = token_reg;

endmodule

FILE: bench/nur_policy_checker.sv
`timescale 1ns / 100ps
// Checker for nur_replacement_policy: watches the input, result and configuration
// ports, predicts each result in order and counts mismatches. Depends on nur_pkg.

module nur_policy_checker #(
    parameter logic [2:0] PERIOD_ADDR = 3'd0
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [7:0]  s_tdata,   // block_index[3:0], block_valid[4], block_modified[5], 0
    input  logic [2:0]  s_tuser,   // req_type[2:0]
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [7:0]  m_tdata,   // victim_index[3:0], references_cleared[4], 0
    input  logic        m_tuser,   // victim_given[0]
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    input  logic        pready,
    output int          errors,
    output int          pending,
    output int          victims_checked,
    output int          clears_checked
);
    import nur_pkg::*;

    // rank bound above any 2*referenced + modified
    localparam logic [2:0] RANK_CEILING = 3'h4;

    typedef struct packed {
        logic [BLK_W-1:0] victim;
        logic             given;
        logic             cleared;
    } policy_answer_t;

    // shadow of the policy state
    logic [PERIOD_W-1:0]   deref_period;
    logic [PERIOD_W-1:0]   clear_count;
    logic [NUM_BLOCKS-1:0] valid_bits;
    logic [NUM_BLOCKS-1:0] mod_bits;
    logic [NUM_BLOCKS-1:0] ref_bits;

    policy_answer_t answers_due[$];

    initial begin
        errors          = 0;
        pending         = 0;
        victims_checked = 0;
        clears_checked  = 0;
    end

    task automatic report_mismatch(input string what, input int got, input int want);
        errors++;
        $display("mismatch at %0t: %s got %0d expected %0d", $time, what, got, want);
    endtask

    // lowest invalid block, else first block with the smallest 2*R+M
    function automatic logic [BLK_W-1:0] choose_victim();
        logic [BLK_W-1:0] best;
        logic [2:0]       best_rank;
        logic [2:0]       rank;
        logic             found;
        int               i;
        best      = '0;
        best_rank = RANK_CEILING;
        found     = 1'b0;
        for (i = 0; i < NUM_BLOCKS; i++) begin
            if (!found && !valid_bits[i]) begin
                best  = i[BLK_W-1:0];
                found = 1'b1;
            end
        end
        if (!found) begin
            for (i = 0; i < NUM_BLOCKS; i++) begin
                rank = {1'b0, ref_bits[i], mod_bits[i]};
                if (rank < best_rank) begin
                    best_rank = rank;
                    best      = i[BLK_W-1:0];
                end
            end
        end
        return best;
    endfunction

    // updates the shadow state for one request and returns its answer;
    // a 4-bit index always falls inside the sixteen blocks
    function automatic policy_answer_t apply_request(input logic [2:0] req,
                                                     input logic [BLK_W-1:0] idx,
                                                     input logic new_valid,
                                                     input logic new_mod);
        policy_answer_t ans;
        ans = '0;
        case (req)
            REQ_READ, REQ_WRITE: begin
                if (deref_period != '0) begin
                    clear_count = clear_count - 1'b1;
                    if (clear_count == '0) begin
                        ref_bits    = '0;
                        clear_count = deref_period;
                        ans.cleared = 1'b1;
                    end
                end
                ref_bits[idx] = 1'b1;
            end
            REQ_REPLACE: begin
                ans.victim = choose_victim();
                ans.given  = 1'b1;
            end
            REQ_CLEAR: begin
                if (deref_period != '0) begin
                    ref_bits    = '0;
                    clear_count = deref_period;
                    ans.cleared = 1'b1;
                end
            end
            REQ_STATUS: begin
                valid_bits[idx] = new_valid;
                mod_bits[idx]   = new_mod;
            end
            default: ;
        endcase
        return ans;
    endfunction

    // predict on accepted input, compare on accepted result
    always @(posedge aclk) begin : watch
        policy_answer_t got;
        policy_answer_t want;
        if (!aresetn) begin
            deref_period = PERIOD_RESET;
            clear_count  = PERIOD_RESET;
            valid_bits   = '0;
            mod_bits     = '0;
            ref_bits     = '0;
            answers_due.delete();
        end else begin
            if (psel && penable && pwrite && pready && paddr == PERIOD_ADDR) begin
                deref_period = pwdata[PERIOD_W-1:0];
                clear_count  = pwdata[PERIOD_W-1:0];
            end
            if (s_tvalid && s_tready)
                answers_due.push_back(apply_request(s_tuser, s_tdata[3:0],
                                                    s_tdata[4], s_tdata[5]));
            if (m_tvalid && m_tready) begin
                got.victim  = m_tdata[3:0];
                got.cleared = m_tdata[4];
                got.given   = m_tuser;
                if (answers_due.size() == 0) begin
                    report_mismatch("result transaction with none outstanding, victim",
                                    got.victim, 0);
                end else begin
                    want = answers_due.pop_front();
                    if (got.victim != want.victim)
                        report_mismatch("victim_index", got.victim, want.victim);
                    if (got.given != want.given)
                        report_mismatch("victim_given", got.given, want.given);
                    if (got.cleared != want.cleared)
                        report_mismatch("references_cleared", got.cleared, want.cleared);
                    if (want.given)
                        victims_checked++;
                    if (want.cleared)
                        clears_checked++;
                end
            end
        end
        pending <= answers_due.size();
    end

endmodule

FILE: bench/tb_nur_replacement_policy.sv
`timescale 1ns / 100ps
// Testbench top for nur_replacement_policy: drives requests, period writes and
// result backpressure; checking is done in nur_policy_checker. Depends on nur_pkg.

module tb_nur_replacement_policy;
    import nur_pkg::*;

    localparam logic [2:0] PERIOD_ADDR      = 3'd0;
    localparam logic [2:0] REQ_UNUSED_FIRST = 3'd5;
    localparam logic [2:0] REQ_UNUSED_LAST  = 3'd7;
    localparam int         RANDOM_PER_STEP  = 55;

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [7:0]  s_tdata;   // block_index[3:0], block_valid[4], block_modified[5], 0
    logic [2:0]  s_tuser;   // req_type[2:0]
    logic        m_tvalid;
    logic        m_tready;
    logic [7:0]  m_tdata;   // victim_index[3:0], references_cleared[4], 0
    logic        m_tuser;   // victim_given[0]
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    int errors;
    int pending;
    int victims_checked;
    int clears_checked;
    int sent_count;
    int send_gap_pct;
    int recv_stall_pct;

    nur_replacement_policy uut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    nur_policy_checker #(.PERIOD_ADDR(PERIOD_ADDR)) u_checker (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_tvalid        (s_tvalid),
        .s_tready        (s_tready),
        .s_tdata         (s_tdata),
        .s_tuser         (s_tuser),
        .m_tvalid        (m_tvalid),
        .m_tready        (m_tready),
        .m_tdata         (m_tdata),
        .m_tuser         (m_tuser),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .pready          (pready),
        .errors          (errors),
        .pending         (pending),
        .victims_checked (victims_checked),
        .clears_checked  (clears_checked)
    );

    // clock
    initial begin
        aclk = 1'b0;
        forever #4 aclk = ~aclk;
    end

    // watchdog
    initial begin
        #4_000_000;
        $display("Verification failed");
        $finish;
    end

    // result backpressure
    always @(posedge aclk) begin
        m_tready <= ($urandom_range(99) >= recv_stall_pct);
    end

    task automatic set_idling(input int mix);
        case (mix)
            0: begin
                send_gap_pct   = 8;
                recv_stall_pct = 48;
            end
            1: begin
                send_gap_pct   = 48;
                recv_stall_pct = 8;
            end
            default: begin
                send_gap_pct   = 0;
                recv_stall_pct = 0;
            end
        endcase
    endtask

    // one input transaction, with an optional gap ahead of it
    task automatic send_item(input logic [2:0] req, input logic [3:0] idx,
                             input logic new_valid, input logic new_mod);
        if ($urandom_range(99) < send_gap_pct) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(3, 1)) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= req;
        s_tdata  <= {2'b00, new_mod, new_valid, idx};
        do @(posedge aclk); while (!s_tready);
        sent_count++;
    endtask

    // stop sending and let every outstanding result come back
    task automatic drain_results();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (pending != 0) @(posedge aclk);
        repeat (NUM_BLOCKS + 4) @(posedge aclk);
    endtask

    task automatic apb_write(input logic [2:0] addr, input logic [31:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // upper bits of the bus word carry noise, the register keeps 16 bits
    task automatic program_period(input logic [15:0] period);
        logic [31:0] word;
        word        = $urandom;
        word[15:0]  = period;
        drain_results();
        apb_write(PERIOD_ADDR, word);
    endtask

    // mostly accesses and status updates, with replaces, clears and unused request codes mixed in
    task automatic send_random_op();
        int         pick;
        logic [2:0] req;
        pick = $urandom_range(99);
        if (pick < 45)
            req = $urandom_range(1) ? REQ_WRITE : REQ_READ;
        else if (pick < 70)
            req = REQ_STATUS;
        else if (pick < 90)
            req = REQ_REPLACE;
        else if (pick < 97)
            req = REQ_CLEAR;
        else
            req = 3'($urandom_range(REQ_UNUSED_LAST, REQ_UNUSED_FIRST));
        send_item(req, 4'($urandom_range(NUM_BLOCKS - 1)), $urandom_range(99) < 88,
                  1'($urandom_range(1)));
    endtask

    // stimulus
    initial begin : stimulus
        int step;
        int n;
        int blk;
        s_tvalid   <= 1'b0;
        s_tdata    <= '0;
        s_tuser    <= REQ_READ;
        psel       <= 1'b0;
        penable    <= 1'b0;
        pwrite     <= 1'b0;
        paddr      <= PERIOD_ADDR;
        pwdata     <= '0;
        sent_count = 0;
        set_idling(0);
        aresetn    <= 1'b0;
        repeat (4) @(posedge aclk);
        aresetn    <= 1'b1;
        @(posedge aclk);

        // directed: empty cache, status updates, clears at the reset period
        send_item(REQ_REPLACE, 4'd0, 1'b0, 1'b0);
        send_item(REQ_STATUS, 4'd0, 1'b1, 1'b1);
        send_item(REQ_STATUS, 4'd1, 1'b1, 1'b0);
        send_item(REQ_REPLACE, 4'd15, 1'b1, 1'b1);
        send_item(REQ_READ, 4'd15, 1'b0, 1'b0);
        send_item(REQ_WRITE, 4'd0, 1'b1, 1'b1);
        send_item(REQ_CLEAR, 4'd0, 1'b0, 1'b0);
        send_item(REQ_UNUSED_LAST, 4'd15, 1'b1, 1'b1);
        send_item(REQ_STATUS, 4'd15, 1'b0, 1'b1);

        // directed: a zero period never clears
        program_period(16'd0);
        send_item(REQ_CLEAR, 4'd3, 1'b0, 1'b0);
        send_item(REQ_READ, 4'd3, 1'b0, 1'b0);
        send_item(REQ_WRITE, 4'd3, 1'b0, 1'b0);

        // directed: a period of one clears on every access
        program_period(16'd1);
        send_item(REQ_READ, 4'd5, 1'b0, 1'b0);
        send_item(REQ_WRITE, 4'd9, 1'b0, 1'b0);
        send_item(REQ_REPLACE, 4'd0, 1'b0, 1'b0);

        // random: two period settings under each idling mix
        for (step = 0; step < 6; step++) begin
            case (step)
                0: program_period(16'($urandom_range(12, 2)));
                1: program_period(16'd0);
                2: program_period(16'hFFFF);
                3: program_period(16'($urandom_range(40, 13)));
                4: program_period(16'd1);
                default: program_period(16'($urandom_range(8, 2)));
            endcase
            if (step % 2 == 0) begin
                set_idling(step / 2);
                // fill the cache so replaces rank referenced and modified bits
                for (blk = 0; blk < NUM_BLOCKS; blk++)
                    send_item(REQ_STATUS, blk[3:0], 1'b1, 1'($urandom_range(1)));
            end
            for (n = 0; n < RANDOM_PER_STEP; n++)
                send_random_op();
        end

        drain_results();
        $display("ran %0d request transactions over several period settings and idling mixes",
                 sent_count);
        $display("checked %0d victim choices and %0d reference clears",
                 victims_checked, clears_checked);
        if (errors == 0 && pending == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
